FILE: sv/spq_pkg.sv
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

    localparam int unsigned DEF_CAPACITY    = 16;
    localparam int unsigned DEF_VALUE_WIDTH = 32;
    localparam int unsigned DEF_RANK_WIDTH  = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: sv/sorted_priority_queue.sv
// sorted priority queue built from a row of compare-and-shift cells
//
//   channel   ports                                             transfer when
//   command   i_opcode, i_item_value, i_item_rank               start && !busy
//   result    o_status, o_removed_*, o_head_*, o_held_count,    o_valid
//             o_is_empty
//
// one command per cycle; busy stays low, every cell updates in the same edge
// the result appears on the cycle after the command transfer, for one cycle
// the cost per command is one rank compare per cell plus the neighbor select
// reset empties the queue at once; slot contents are not cleared
// the result side cannot stall, so nothing is ever held back
`default_nettype none

module sorted_priority_queue #(
    parameter int unsigned CAPACITY    = spq_pkg::DEF_CAPACITY,
    parameter int unsigned VALUE_WIDTH = spq_pkg::DEF_VALUE_WIDTH,
    parameter int unsigned RANK_WIDTH  = spq_pkg::DEF_RANK_WIDTH,
    localparam int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire                           i_opcode,
    input  wire        [VALUE_WIDTH-1:0]  i_item_value,
    input  wire signed [RANK_WIDTH-1:0]   i_item_rank,
    output logic                          o_valid,
    output logic       [1:0]              o_status,
    output logic       [VALUE_WIDTH-1:0]  o_removed_value,
    output logic signed [RANK_WIDTH-1:0]  o_removed_rank,
    output logic       [VALUE_WIDTH-1:0]  o_head_value,
    output logic signed [RANK_WIDTH-1:0]  o_head_rank,
    output logic       [CNT_W-1:0]        o_held_count,
    output logic                          o_is_empty
);
    import spq_pkg::*;

    logic                          w_stay  [CAPACITY];
    logic        [VALUE_WIDTH-1:0] w_value [CAPACITY];
    logic signed [RANK_WIDTH-1:0]  w_rank  [CAPACITY];

    logic                          r_valid;
    t_status                       r_status;
    logic        [VALUE_WIDTH-1:0] r_removed_value;
    logic signed [RANK_WIDTH-1:0]  r_removed_rank;
    logic        [CNT_W-1:0]       r_count;

    t_status                       n_status;
    logic        [CNT_W-1:0]       n_count;
    logic        [VALUE_WIDTH-1:0] n_removed_value;
    logic signed [RANK_WIDTH-1:0]  n_removed_rank;
    t_cell_ctrl                    w_ctrl;
    logic                          w_accept;
    logic                          w_full;
    logic                          w_empty;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    always_comb begin
        w_ctrl          = '0;
        n_status        = ST_DONE;
        n_count         = r_count;
        n_removed_value = '0;
        n_removed_rank  = '0;
        if (w_accept) begin
            if (t_opcode'(i_opcode) == OP_INSERT) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctrl.ins = 1'b1;
                    n_count    = r_count + CNT_W'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctrl.rem      = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                    n_removed_value = w_value[0];
                    n_removed_rank  = w_rank[0];
                end
            end
        end
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                          w_prev_stay;
        logic        [VALUE_WIDTH-1:0] w_prev_value;
        logic signed [RANK_WIDTH-1:0]  w_prev_rank;
        logic        [VALUE_WIDTH-1:0] w_next_value;
        logic signed [RANK_WIDTH-1:0]  w_next_rank;

        if (gi == 0) begin : g_first
            // the head has nothing ahead of it, so it takes the new item directly
            assign w_prev_stay  = 1'b1;
            assign w_prev_value = i_item_value;
            assign w_prev_rank  = i_item_rank;
        end else begin : g_mid
            assign w_prev_stay  = w_stay[gi-1];
            assign w_prev_value = w_value[gi-1];
            assign w_prev_rank  = w_rank[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_next_value = w_value[gi];
            assign w_next_rank  = w_rank[gi];
        end else begin : g_body
            assign w_next_value = w_value[gi+1];
            assign w_next_rank  = w_rank[gi+1];
        end

        spq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .RANK_WIDTH  (RANK_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_occ        (CNT_W'(gi) < r_count),
            .i_new_value  (i_item_value),
            .i_new_rank   (i_item_rank),
            .i_prev_stay  (w_prev_stay),
            .i_prev_value (w_prev_value),
            .i_prev_rank  (w_prev_rank),
            .i_next_value (w_next_value),
            .i_next_rank  (w_next_rank),
            .o_stay       (w_stay[gi]),
            .o_value      (w_value[gi]),
            .o_rank       (w_rank[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_count  <= '0;
            r_status <= ST_DONE;
        end else begin
            r_valid  <= w_accept;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_removed_value <= n_removed_value;
        r_removed_rank  <= n_removed_rank;
    end

    // head read straight from the cells after the update, count from the held-count register
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed_value;
    assign o_removed_rank  = r_removed_rank;
    assign o_head_value    = w_empty ? '0 : w_value[0];
    assign o_head_rank     = w_empty ? '0 : w_rank[0];
    assign o_held_count    = r_count;
    assign o_is_empty      = w_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("result strobe missing after command transfer");

    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> w_full)
        else $error("full refusal while not full");

    a_empty_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> o_is_empty)
        else $error("empty refusal while items held");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_status == ST_DONE) |=> (r_count != $past(r_count)))
        else $error("count unchanged after a completed command");

endmodule

`default_nettype wire

FILE: sv/spq_cell.sv
// one slot of the sorted row: keeps, takes the new item, or shifts from a neighbor
`default_nettype none

module spq_cell #(
    parameter int unsigned VALUE_WIDTH = spq_pkg::DEF_VALUE_WIDTH,
    parameter int unsigned RANK_WIDTH  = spq_pkg::DEF_RANK_WIDTH
) (
    input  wire                          i_clk,
    input  wire spq_pkg::t_cell_ctrl     i_ctrl,
    input  wire                          i_occ,
    input  wire        [VALUE_WIDTH-1:0] i_new_value,
    input  wire signed [RANK_WIDTH-1:0]  i_new_rank,
    input  wire                          i_prev_stay,
    input  wire        [VALUE_WIDTH-1:0] i_prev_value,
    input  wire signed [RANK_WIDTH-1:0]  i_prev_rank,
    input  wire        [VALUE_WIDTH-1:0] i_next_value,
    input  wire signed [RANK_WIDTH-1:0]  i_next_rank,
    output logic                         o_stay,
    output logic       [VALUE_WIDTH-1:0] o_value,
    output logic signed [RANK_WIDTH-1:0] o_rank
);
    import spq_pkg::*;

    logic        [VALUE_WIDTH-1:0] r_value;
    logic signed [RANK_WIDTH-1:0]  r_rank;
    logic        [VALUE_WIDTH-1:0] n_value;
    logic signed [RANK_WIDTH-1:0]  n_rank;

    // held item keeps its place when its priority is at least the new one
    assign o_stay  = i_occ && (r_rank >= i_new_rank);
    assign o_value = r_value;
    assign o_rank  = r_rank;

    always_comb begin
        n_value = r_value;
        n_rank  = r_rank;
        if (i_ctrl.ins && !o_stay) begin
            if (i_prev_stay) begin
                n_value = i_new_value;
                n_rank  = i_new_rank;
            end else begin
                n_value = i_prev_value;
                n_rank  = i_prev_rank;
            end
        end else if (i_ctrl.rem) begin
            n_value = i_next_value;
            n_rank  = i_next_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_rank  <= n_rank;
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking testbench for the sorted priority queue
module tb;
    import spq_pkg::*;

    localparam int unsigned CAPACITY     = DEF_CAPACITY;
    localparam int          RANDOM_ITEMS = 1900;
    localparam int          QUIET_TAIL   = 200;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef struct packed {
        t_status            status;
        logic [31:0]        removed_value;
        logic signed [15:0] removed_rank;
        logic [31:0]        head_value;
        logic signed [15:0] head_rank;
        logic [4:0]         held_count;
        logic               is_empty;
    } queue_answer_t;

    typedef struct packed {
        t_opcode            op;
        logic [31:0]        value;
        logic signed [15:0] rank;
        logic               pinned;
        queue_answer_t      answer;
    } dir_row_t;

    localparam queue_answer_t NO_ANSWER = '0;

    // rows with pinned answers carry them typed in; the rest go through the predictor
    localparam dir_row_t DIR_ROWS [23] = '{
        '{OP_REMOVE, 32'h0000_0000, 16'sh0000, 1'b1,
          '{ST_EMPTY, 32'h0, 16'sh0, 32'h0, 16'sh0, 5'd0, 1'b1}},
        '{OP_INSERT, 32'hFFFF_FFFF, 16'sh7FFF, 1'b1,
          '{ST_DONE, 32'h0, 16'sh0, 32'hFFFF_FFFF, 16'sh7FFF, 5'd1, 1'b0}},
        '{OP_INSERT, 32'h0000_0000, 16'sh8000, 1'b1,
          '{ST_DONE, 32'h0, 16'sh0, 32'hFFFF_FFFF, 16'sh7FFF, 5'd2, 1'b0}},
        '{OP_INSERT, 32'h0000_0001, 16'sh0000, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_0002, 16'sh0000, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_0003, 16'sh7FFF, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'hAAAA_AAAA, 16'sh5555, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h5555_5555, 16'shAAAA, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_0004, 16'shFFFF, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_0005, 16'sh0001, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_0006, 16'sh8000, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_0007, 16'sh0000, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_0008, 16'sh0064, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_0009, 16'shFF9C, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_000A, 16'sh7FFE, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_000B, 16'sh8001, 1'b0, NO_ANSWER},
        '{OP_INSERT, 32'h0000_000C, 16'sh0002, 1'b0, NO_ANSWER},
        // queue is full here, the insert is refused
        '{OP_INSERT, 32'h1234_5678, 16'sh7FFF, 1'b1,
          '{ST_FULL, 32'h0, 16'sh0, 32'hFFFF_FFFF, 16'sh7FFF, 5'd16, 1'b0}},
        '{OP_REMOVE, 32'hDEAD_BEEF, 16'sh1234, 1'b0, NO_ANSWER},
        '{OP_REMOVE, 32'h0000_0000, 16'sh0000, 1'b0, NO_ANSWER},
        '{OP_REMOVE, 32'hFFFF_FFFF, 16'shFFFF, 1'b0, NO_ANSWER},
        '{OP_REMOVE, 32'h0000_0000, 16'sh8000, 1'b0, NO_ANSWER},
        '{OP_REMOVE, 32'h0000_0000, 16'sh0000, 1'b0, NO_ANSWER}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_opcode;
    logic [31:0]        i_item_value;
    logic signed [15:0] i_item_rank;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [31:0]        o_removed_value;
    logic signed [15:0] o_removed_rank;
    logic [31:0]        o_head_value;
    logic signed [15:0] o_head_rank;
    logic [4:0]         o_held_count;
    logic               o_is_empty;

    // pinned answer travels with the command and is sampled at its transfer
    logic               drv_pinned;
    queue_answer_t      drv_pin_answer;

    logic [31:0]        mdl_value [CAPACITY];
    logic signed [15:0] mdl_rank [CAPACITY];
    int                 mdl_count;

    queue_answer_t      pending_answers [$];
    int                 mismatch_cnt;
    int                 cycle_cnt;

    sorted_priority_queue u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_item_rank     (i_item_rank),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_removed_rank  (o_removed_rank),
        .o_head_value    (o_head_value),
        .o_head_rank     (o_head_rank),
        .o_held_count    (o_held_count),
        .o_is_empty      (o_is_empty)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic queue_answer_t predict_queue_op(input t_opcode op,
                                                       input logic [31:0] value,
                                                       input logic signed [15:0] rank);
        queue_answer_t ans;
        int            i;
        ans = '0;
        ans.status = ST_DONE;
        if (op == OP_INSERT) begin
            if (mdl_count >= CAPACITY) begin
                ans.status = ST_FULL;
            end else begin
                // new item goes behind every held item of equal or higher rank
                i = mdl_count;
                while (i > 0 && mdl_rank[i-1] < rank) begin
                    mdl_value[i] = mdl_value[i-1];
                    mdl_rank[i]  = mdl_rank[i-1];
                    i--;
                end
                mdl_value[i] = value;
                mdl_rank[i]  = rank;
                mdl_count++;
            end
        end else if (mdl_count == 0) begin
            ans.status = ST_EMPTY;
        end else begin
            ans.removed_value = mdl_value[0];
            ans.removed_rank  = mdl_rank[0];
            for (i = 0; i + 1 < mdl_count; i++) begin
                mdl_value[i] = mdl_value[i+1];
                mdl_rank[i]  = mdl_rank[i+1];
            end
            mdl_count--;
        end
        if (mdl_count > 0) begin
            ans.head_value = mdl_value[0];
            ans.head_rank  = mdl_rank[0];
        end
        ans.held_count = 5'(mdl_count);
        ans.is_empty   = (mdl_count == 0);
        return ans;
    endfunction

    always @(posedge i_clk) begin : answer_check
        queue_answer_t got;
        queue_answer_t want;
        if (i_rst_n) begin
            if (o_valid) begin
                got = '{t_status'(o_status), o_removed_value, o_removed_rank,
                        o_head_value, o_head_rank, o_held_count, o_is_empty};
                if (pending_answers.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result status %0d head %h/%0d count %0d",
                             $time, o_status, o_head_value, o_head_rank, o_held_count);
                end else begin
                    want = pending_answers.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        $display("%0t: mismatch exp st=%0d rm=%h/%0d hd=%h/%0d n=%0d e=%0d",
                                 $time, want.status, want.removed_value, want.removed_rank,
                                 want.head_value, want.head_rank, want.held_count,
                                 want.is_empty);
                        $display("%0t:          got st=%0d rm=%h/%0d hd=%h/%0d n=%0d e=%0d",
                                 $time, got.status, got.removed_value, got.removed_rank,
                                 got.head_value, got.head_rank, got.held_count,
                                 got.is_empty);
                    end
                end
            end
            if (start && !busy) begin
                want = predict_queue_op(t_opcode'(i_opcode), i_item_value, i_item_rank);
                if (drv_pinned) begin
                    want = drv_pin_answer;
                end
                pending_answers.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // holds the command until its transfer, returns at the transfer edge
    task automatic send_cmd(input t_opcode op, input logic [31:0] value,
                            input logic signed [15:0] rank, input logic pin,
                            input queue_answer_t ans);
        start          <= 1'b1;
        i_opcode       <= op;
        i_item_value   <= value;
        i_item_rank    <= rank;
        drv_pinned     <= pin;
        drv_pin_answer <= ans;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_opcode            op;
        logic [31:0]        value;
        logic signed [15:0] rank;
        int                 ins_pct;
        bit                 gaps_on;
        mismatch_cnt   = 0;
        cycle_cnt      = 0;
        mdl_count      = 0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_opcode       <= OP_INSERT;
        i_item_value   <= '0;
        i_item_rank    <= '0;
        drv_pinned     <= 1'b0;
        drv_pin_answer <= NO_ANSWER;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[k]) begin
            send_cmd(DIR_ROWS[k].op, DIR_ROWS[k].value, DIR_ROWS[k].rank,
                     DIR_ROWS[k].pinned, DIR_ROWS[k].answer);
            if ($urandom_range(3) == 0) begin
                idle_gap($urandom_range(1, 12));
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // phases lean toward inserts, toward removes, then balanced
            case ((n / 150) % 3)
                0:       ins_pct = 80;
                1:       ins_pct = 20;
                default: ins_pct = 50;
            endcase
            gaps_on = ((n / 75) % 2 == 0) && (n < RANDOM_ITEMS - QUIET_TAIL);
            op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
            case ($urandom_range(7))
                0:       value = 32'h0000_0000;
                1:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase
            case ($urandom_range(7))
                0:       rank = 16'sh8000;
                1:       rank = 16'sh7FFF;
                2, 3:    rank = $signed(16'($urandom_range(0, 4))) - 16'sd2;  // many ties
                default: rank = $signed(16'($urandom));
            endcase
            send_cmd(op, value, rank, 1'b0, NO_ANSWER);
            if (n == RANDOM_ITEMS / 2 ||
                (n % 150 == 149 && n < RANDOM_ITEMS - QUIET_TAIL)) begin
                wait_drained();
            end else if (gaps_on && $urandom_range(4) == 0) begin
                idle_gap($urandom_range(1, 12));
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
